>>> hw/rtl/mexp_pkg.sv
// Package for the modular exponentiation block: widths, microcode word layout,
// control/status structs and the microcode program ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	localparam int W         = 32;                    // operand width
	localparam int CNT_W     = $clog2(W + 1);         // bit counter, holds W
	localparam int PC_W      = 5;                     // microcode address
	localparam int IN_DATA_W  = ((2 * W + 7) / 8) * 8; // value_a, value_b
	localparam int OUT_DATA_W = ((W + 7) / 8) * 8;     // result

	typedef enum logic [3:0] {
		OP_NOP   = 4'd0,
		OP_RINIT = 4'd1,  // r = 0, cnt = W, mb = reg(sa)
		OP_RSTEP = 4'd2,  // restoring reduction step of mb into r
		OP_MINIT = 4'd3,  // r = 0, cnt = W, ma = reg(sa), mb = reg(sb)
		OP_MDBL  = 4'd4,  // r = 2r mod m
		OP_MADD  = 4'd5,  // if mb msb: r = r + ma mod m; mb <<= 1; cnt--
		OP_WR    = 4'd6,  // reg(sa) = r
		OP_ESHR  = 4'd7,  // e >>= 1
		OP_CLR   = 4'd8,  // acc = 0
		OP_DONE  = 4'd9   // hand acc to the output register
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER  = 3'd0,
		C_ALWAYS = 3'd1,
		C_MZERO  = 3'd2,
		C_EZERO  = 3'd3,
		C_EBIT0  = 3'd4,
		C_MORE   = 3'd5,
		C_NOTDIV = 3'd6
	} cond_t;

	typedef enum logic [1:0] {
		REG_ACC = 2'd0,
		REG_SQ  = 2'd1,
		REG_TA  = 2'd2
	} rsel_t;

	typedef struct packed {
		op_t              op;
		rsel_t            sa;
		rsel_t            sb;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ucw_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic mzero;
		logic ezero;
		logic ebit0;
		logic more;
		logic notdiv;
		logic out_free;
	} stat_t;

	// program labels
	localparam logic [PC_W-1:0] L_EXP   = PC_W'(4);
	localparam logic [PC_W-1:0] L_SQ    = PC_W'(10);
	localparam logic [PC_W-1:0] L_FIN   = PC_W'(15);
	localparam logic [PC_W-1:0] L_ZERO  = PC_W'(23);
	localparam logic [PC_W-1:0] L_DONE  = PC_W'(24);
	localparam logic [PC_W-1:0] PC_LAST = L_DONE;

	function automatic ucw_t mk(op_t op, rsel_t sa, rsel_t sb, cond_t cond,
	                            logic [PC_W-1:0] target);
		ucw_t w;
		w.op     = op;
		w.sa     = sa;
		w.sb     = sb;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// Right-to-left square-and-multiply, then the divide-mode final product.
	function automatic ucw_t rom(logic [PC_W-1:0] pc);
		ucw_t w;
		case (pc)
			5'd0:  w = mk(OP_NOP,   REG_ACC, REG_ACC, C_MZERO,  L_ZERO);
			5'd1:  w = mk(OP_RINIT, REG_SQ,  REG_ACC, C_NEVER,  '0);
			5'd2:  w = mk(OP_RSTEP, REG_ACC, REG_ACC, C_MORE,   PC_W'(2));
			5'd3:  w = mk(OP_WR,    REG_SQ,  REG_ACC, C_NEVER,  '0);
			5'd4:  w = mk(OP_NOP,   REG_ACC, REG_ACC, C_EZERO,  L_FIN);
			5'd5:  w = mk(OP_NOP,   REG_ACC, REG_ACC, C_EBIT0,  L_SQ);
			5'd6:  w = mk(OP_MINIT, REG_SQ,  REG_ACC, C_NEVER,  '0);
			5'd7:  w = mk(OP_MDBL,  REG_ACC, REG_ACC, C_NEVER,  '0);
			5'd8:  w = mk(OP_MADD,  REG_ACC, REG_ACC, C_MORE,   PC_W'(7));
			5'd9:  w = mk(OP_WR,    REG_ACC, REG_ACC, C_NEVER,  '0);
			5'd10: w = mk(OP_MINIT, REG_SQ,  REG_SQ,  C_NEVER,  '0);
			5'd11: w = mk(OP_MDBL,  REG_ACC, REG_ACC, C_NEVER,  '0);
			5'd12: w = mk(OP_MADD,  REG_ACC, REG_ACC, C_MORE,   PC_W'(11));
			5'd13: w = mk(OP_WR,    REG_SQ,  REG_ACC, C_NEVER,  '0);
			5'd14: w = mk(OP_ESHR,  REG_ACC, REG_ACC, C_ALWAYS, L_EXP);
			5'd15: w = mk(OP_NOP,   REG_ACC, REG_ACC, C_NOTDIV, L_DONE);
			5'd16: w = mk(OP_RINIT, REG_TA,  REG_ACC, C_NEVER,  '0);
			5'd17: w = mk(OP_RSTEP, REG_ACC, REG_ACC, C_MORE,   PC_W'(17));
			5'd18: w = mk(OP_WR,    REG_TA,  REG_ACC, C_NEVER,  '0);
			5'd19: w = mk(OP_MINIT, REG_TA,  REG_ACC, C_NEVER,  '0);
			5'd20: w = mk(OP_MDBL,  REG_ACC, REG_ACC, C_NEVER,  '0);
			5'd21: w = mk(OP_MADD,  REG_ACC, REG_ACC, C_MORE,   PC_W'(20));
			5'd22: w = mk(OP_WR,    REG_ACC, REG_ACC, C_ALWAYS, L_DONE);
			5'd23: w = mk(OP_CLR,   REG_ACC, REG_ACC, C_NEVER,  '0);
			default: w = mk(OP_DONE, REG_ACC, REG_ACC, C_NEVER, '0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mexp_seq.sv
// Microcode sequencer: step counter, busy flag, program ROM and jump logic.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  mexp_pkg::stat_t      stat,
	output logic                 busy,
	output mexp_pkg::ucw_t       cw
);
	import mexp_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            take;

	assign cw   = rom(pc_q);
	assign busy = busy_q;

	always_comb begin
		case (cw.cond)
			C_NEVER:  take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_MZERO:  take = stat.mzero;
			C_EZERO:  take = stat.ezero;
			C_EBIT0:  take = stat.ebit0;
			C_MORE:   take = stat.more;
			C_NOTDIV: take = stat.notdiv;
			default:  take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (busy_q) begin
			if (cw.op == OP_DONE) begin
				if (stat.out_free) busy_q <= 1'b0;
			end else if (take) begin
				pc_q <= cw.target;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= PC_LAST)
		else $error("pc left program");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cw.op == OP_DONE && stat.out_free) |=> !busy_q)
		else $error("busy held after done");

endmodule

`default_nettype wire

>>> hw/rtl/mexp_dp.sv
// Datapath: modulus register, operand registers, modular add/reduce unit,
// bit counter and the output register. Driven by the microcode word.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wen,
	input  wire  [mexp_pkg::W-1:0]      cfg_wdata,
	input  wire                         start,
	input  wire                         action,
	input  wire  [mexp_pkg::W-1:0]      value_a,
	input  wire  [mexp_pkg::W-1:0]      value_b,
	input  wire                         busy,
	input  mexp_pkg::ucw_t              cw,
	output mexp_pkg::stat_t             stat,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [mexp_pkg::W-1:0]      out_data
);
	import mexp_pkg::*;

	logic [W-1:0]     m_q, acc_q, sq_q, ta_q, e_q, ma_q, mb_q, r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             dv_q;
	logic             out_valid_q;
	logic [W-1:0]     out_q;

	logic [W:0]       sum, diff;
	logic [W-1:0]     red, src_a, src_b;
	logic             out_free;

	function automatic logic [W-1:0] pick(rsel_t s, logic [W-1:0] acc,
	                                      logic [W-1:0] sq, logic [W-1:0] ta);
		logic [W-1:0] v;
		case (s)
			REG_ACC: v = acc;
			REG_SQ:  v = sq;
			REG_TA:  v = ta;
			default: v = acc;
		endcase
		return v;
	endfunction

	assign src_a = pick(cw.sa, acc_q, sq_q, ta_q);
	assign src_b = pick(cw.sb, acc_q, sq_q, ta_q);

	// shared add then conditional subtract; inputs always sum below 2m
	always_comb begin
		case (cw.op)
			OP_RSTEP: sum = {r_q, mb_q[W-1]};
			OP_MDBL:  sum = {1'b0, r_q} + {1'b0, r_q};
			OP_MADD:  sum = {1'b0, r_q} + {1'b0, ma_q};
			default:  sum = {1'b0, r_q};
		endcase
		diff = sum - {1'b0, m_q};
		red  = (sum >= {1'b0, m_q}) ? diff[W-1:0] : sum[W-1:0];
	end

	assign out_free      = !out_valid_q || out_ready;
	assign stat.mzero    = (m_q == '0);
	assign stat.ezero    = (e_q == '0);
	assign stat.ebit0    = !e_q[0];
	assign stat.more     = (cnt_q != CNT_W'(1));
	assign stat.notdiv   = !dv_q;
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= W'(1);
		end else if (cfg_wen) begin
			m_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy && cw.op == OP_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= action;
			acc_q <= W'(1);
			ta_q  <= value_a;
			if (!action) begin
				sq_q <= value_a;
				e_q  <= value_b;
			end else begin
				sq_q <= value_b;
				e_q  <= (m_q >= W'(2)) ? (m_q - W'(2)) : '0;
			end
		end else if (busy) begin
			case (cw.op)
				OP_RINIT: begin
					r_q   <= '0;
					cnt_q <= CNT_W'(W);
					mb_q  <= src_a;
				end
				OP_RSTEP: begin
					r_q   <= red;
					mb_q  <= mb_q << 1;
					cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_MINIT: begin
					r_q   <= '0;
					cnt_q <= CNT_W'(W);
					ma_q  <= src_a;
					mb_q  <= src_b;
				end
				OP_MDBL: r_q <= red;
				OP_MADD: begin
					if (mb_q[W-1]) r_q <= red;
					mb_q  <= mb_q << 1;
					cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_WR: begin
					case (cw.sa)
						REG_ACC: acc_q <= r_q;
						REG_SQ:  sq_q  <= r_q;
						REG_TA:  ta_q  <= r_q;
						default: acc_q <= r_q;
					endcase
				end
				OP_ESHR: e_q   <= e_q >> 1;
				OP_CLR:  acc_q <= '0;
				OP_DONE: if (out_free) out_q <= acc_q;
				default: ;
			endcase
		end
	end

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !start && (cw.op == OP_RSTEP || cw.op == OP_MADD)) |-> cnt_q != '0)
		else $error("bit counter underflow");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !start && cw.op == OP_DONE && out_free) |=> out_valid_q)
		else $error("result not presented");

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: stream ports, config port,
// sequencer and datapath. Depends on mexp_pkg, mexp_seq, mexp_dp.
`timescale 1ns / 1ps
`default_nettype none

// Computes value_a^value_b mod m (tuser = 0) or value_a * value_b^(m-2) mod m
// (tuser = 1, Fermat division, valid for prime m) by right-to-left
// square-and-multiply. The user must write the modulus m through
// cfg_wen/cfg_wdata only while the block is idle; the block itself does
// not enforce this. m resets to 1. An exponent of zero gives 1; a modulus
// of zero gives 0. One item is in flight at a time: s_axis_tready is low
// from acceptance until the result is placed in the output register, which
// can hold a result while the next beat is taken. Every modular product is
// a shift-and-add over W bits, a double and a conditional add per bit plus
// setup and write-back, run by a microcode program on one shared add/reduce
// unit. Each exponent bit costs two test steps and a shift, plus the square,
// plus the multiply when the bit is set. The base is reduced first; a
// divide adds one more reduction and product.
module modular_exponentiation (
	input  wire                              clk,
	input  wire                              arst_n,
	// modulus register write
	input  wire                              cfg_wen,
	input  wire  [mexp_pkg::W-1:0]           cfg_wdata,
	// input beats
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [mexp_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // value_a, value_b
	input  wire  [0:0]                       s_axis_tuser,  // action
	// result beats
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [mexp_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // result
);
	import mexp_pkg::*;

	logic         busy;
	logic         start;
	ucw_t         cw;
	stat_t        stat;
	logic [W-1:0] result;

	// ready whenever no item is being worked on
	assign s_axis_tready = !busy;
	assign start         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata  = OUT_DATA_W'(result);

	mexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cw     (cw)
	);

	mexp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.action    (s_axis_tuser[0]),
		.value_a   (s_axis_tdata[W-1:0]),
		.value_b   (s_axis_tdata[2*W-1:W]),
		.busy      (busy),
		.cw        (cw),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result)
	);

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for modular_exponentiation: power and Fermat-divide beats
// checked against a behavioral residue predictor. Depends on mexp_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

	import mexp_pkg::*;

	localparam int WD_LIMIT = 100000;  // cycles with no beat before giving up

	typedef enum logic {
		ACT_POW = 1'b0,
		ACT_DIV = 1'b1
	} action_t;

	typedef struct {
		action_t      act;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] m;
		logic [W-1:0] res;
	} residue_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [W-1:0]          cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // value_a, value_b
	logic [0:0]            s_axis_tuser;   // action
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // result

	residue_t     residue_q[$];
	residue_t     head;
	logic [W-1:0] modulus_cur;
	int           err_cnt;
	int           idle_cycles;
	int           rx_hold_len;
	int           rx_stall_left;
	bit           tx_gaps_on;
	bit           rx_stalls_on;

	modular_exponentiation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	// exact (x * y) mod m, m nonzero; product held at double width
	function automatic logic [W-1:0] mulmod(logic [W-1:0] x, logic [W-1:0] y,
	                                        logic [W-1:0] m);
		logic [2*W-1:0] xm;
		logic [2*W-1:0] ym;
		logic [2*W-1:0] prod;
		xm   = {{W{1'b0}}, x} % {{W{1'b0}}, m};
		ym   = {{W{1'b0}}, y} % {{W{1'b0}}, m};
		prod = (xm * ym) % {{W{1'b0}}, m};
		return prod[W-1:0];
	endfunction

	// right-to-left square-and-multiply; zero exponent leaves acc at 1 unreduced
	function automatic logic [W-1:0] powmod(logic [W-1:0] base, logic [W-1:0] e,
	                                        logic [W-1:0] m);
		logic [W-1:0] acc;
		logic [W-1:0] sq;
		acc = 1;
		sq  = base % m;
		while (e != 0) begin
			if (e[0])
				acc = mulmod(acc, sq, m);
			sq = mulmod(sq, sq, m);
			e  = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic [W-1:0] predict_residue(action_t act, logic [W-1:0] a,
	                                                 logic [W-1:0] b, logic [W-1:0] m);
		logic [W-1:0] fermat_e;
		if (m == 0)
			return '0;
		if (act == ACT_POW)
			return powmod(a, b, m);
		fermat_e = (m >= 2) ? m - 2 : '0;
		return mulmod(a, powmod(b, fermat_e, m), m);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 30);
		return $urandom_range(100, 3000);
	endfunction

	task automatic flag_error(string msg);
		if (err_cnt < 10)
			$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// ---------------- result side ----------------

	// tready driven on the falling edge; long holds come from rx_hold_len
	initial begin
		m_axis_tready = 1'b0;
		rx_stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				m_axis_tready = 1'b0;
				rx_hold_len--;
			end else if (rx_stall_left > 0) begin
				m_axis_tready = 1'b0;
				rx_stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				if (rx_stalls_on)
					rx_stall_left = pick_gap();
			end
		end
	end

	// result beat vs. oldest outstanding prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (residue_q.size() == 0) begin
				flag_error($sformatf("result beat %h with nothing outstanding",
				                     m_axis_tdata));
			end else begin
				head = residue_q.pop_front();
				if (m_axis_tdata[W-1:0] !== head.res)
					flag_error($sformatf(
						"%s a=%h b=%h m=%h: expected result %h, got %h",
						head.act.name(), head.a, head.b, head.m, head.res,
						m_axis_tdata[W-1:0]));
			end
		end
	end

	// watchdog: any beat on either side resets the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
			         WD_LIMIT, residue_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------- input side ----------------

	// offer one beat; tvalid stays high afterwards until a gap or a drain
	task automatic send_beat(action_t act, logic [W-1:0] a, logic [W-1:0] b);
		int       gap;
		residue_t item;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid         = 1'b1;
		s_axis_tuser          = act;
		s_axis_tdata          = '0;
		s_axis_tdata[W-1:0]   = a;
		s_axis_tdata[2*W-1:W] = b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		item.act = act;
		item.a   = a;
		item.b   = b;
		item.m   = modulus_cur;
		item.res = predict_residue(act, a, b, modulus_cur);
		residue_q.push_back(item);
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (residue_q.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// modulus written only with the block idle
	task automatic set_modulus(logic [W-1:0] m);
		drain();
		cfg_wen     = 1'b1;
		cfg_wdata   = m;
		modulus_cur = m;
		@(negedge clk);
		cfg_wen     = 1'b0;
	endtask

	// ---------------- tests ----------------

	// reset value of the modulus is 1
	task automatic test_reset_modulus();
		send_beat(ACT_POW, 32'd5, 32'd0);         // zero exponent still gives 1
		send_beat(ACT_POW, 32'd5, 32'd3);
		send_beat(ACT_DIV, 32'd7, 32'd3);         // m < 2: exponent 0, a mod 1
	endtask

	task automatic test_zero_modulus();
		set_modulus('0);
		send_beat(ACT_POW, 32'd3, 32'd4);
		send_beat(ACT_POW, 32'hFFFF_FFFF, 32'd0);
		send_beat(ACT_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_small_prime();
		set_modulus(32'd13);
		send_beat(ACT_POW, 32'd0, 32'd0);
		send_beat(ACT_POW, 32'd0, 32'd5);
		send_beat(ACT_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(ACT_DIV, 32'd10, 32'd4);
		send_beat(ACT_DIV, 32'd5, 32'd26);        // divisor a multiple of m
		send_beat(ACT_DIV, 32'hFFFF_FFFF, 32'd1);
		send_beat(ACT_DIV, 32'd9, 32'd0);
	endtask

	task automatic test_modulus_two();
		set_modulus(32'd2);
		send_beat(ACT_DIV, 32'd7, 32'd3);         // exponent 0, inverse is 1
		send_beat(ACT_POW, 32'd3, 32'd1);
		set_modulus(32'd3);
		send_beat(ACT_DIV, 32'd2, 32'd2);         // Fermat exponent of 1
	endtask

	task automatic test_wide_moduli();
		set_modulus(32'hFFFF_FFFF);               // composite, widest
		send_beat(ACT_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(ACT_POW, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_beat(ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF);
		set_modulus(32'd4294967291);              // largest 32-bit prime
		send_beat(ACT_DIV, 32'd123456789, 32'd987654321);
		send_beat(ACT_DIV, 32'hDEAD_BEEF, 32'd4294967291);
		send_beat(ACT_POW, 32'd2, 32'hFFFF_FFFF);
	endtask

	function automatic logic [W-1:0] pick_modulus();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				case ($urandom_range(0, 6))
					0:       return 32'd3;
					1:       return 32'd5;
					2:       return 32'd251;
					3:       return 32'd65521;
					4:       return 32'd2147483647;
					5:       return 32'd4294967291;
					default: return 32'd1000003;
				endcase
			end
			3, 4, 5: return $urandom;
			6, 7:    return $urandom_range(2, 1000);
			8:       return $urandom_range(0, 1);
			default: return $urandom | 32'h8000_0000;
		endcase
	endfunction

	task automatic send_random();
		action_t      act;
		logic [W-1:0] a;
		logic [W-1:0] b;
		act = action_t'($urandom_range(0, 1));
		a   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom;
		case ($urandom_range(0, 4))
			0:       b = $urandom;
			1:       b = $urandom >> $urandom_range(0, 31);
			2:       b = $urandom_range(0, 15);
			3:       b = $urandom | 32'h8000_0000;
			default: b = (act == ACT_DIV) ? modulus_cur * $urandom_range(0, 3)
			                              : $urandom >> 16;
		endcase
		send_beat(act, a, b);
	endtask

	// several modulus settings, random idling mix per setting
	task automatic test_random(int settings, int per_setting);
		for (int s = 0; s < settings; s++) begin
			set_modulus(pick_modulus());
			tx_gaps_on   = (s != 0) && ($urandom_range(0, 3) != 0);
			rx_stalls_on = (s != 0) && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < per_setting; i++)
				send_random();
		end
	endtask

	// long receiver hold with the sender still offering: result register fills,
	// then the input stalls
	task automatic test_backpressure();
		set_modulus(32'd65521);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		rx_hold_len  = 4000;
		for (int i = 0; i < 6; i++)
			send_beat(action_t'(i & 1), $urandom, $urandom_range(0, 255));
		drain();
	endtask

	// sender pauses until everything is back, then resumes
	task automatic test_pause();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		for (int i = 0; i < 3; i++)
			send_random();
		drain();
		for (int i = 0; i < 3; i++)
			send_random();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		modulus_cur   = 1;
		err_cnt       = 0;
		idle_cycles   = 0;
		rx_hold_len   = 0;
		tx_gaps_on    = 1'b0;
		rx_stalls_on  = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_modulus();
		test_zero_modulus();
		test_small_prime();
		test_modulus_two();
		test_wide_moduli();
		test_backpressure();
		test_pause();
		test_random(8, 14);

		drain();
		// catch any stray result beat
		repeat (200) @(negedge clk);
		if (err_cnt == 0 && residue_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
